>>> hdl/crc32cw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32C wide update package
// Shared widths, the input word type and the constant fold matrix that maps
// one aligned lane of bytes onto the 32-bit remainder.
// ----------------------------------------------------------------------------
package crc32cw_pkg;

  // Field widths
  localparam int unsigned CRC_W   = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 5;

  // Bytes per word: the ports carry at most MAX_BYTES, LANE_BYTES of them count
  localparam int unsigned MAX_BYTES  = 16;
  localparam int unsigned LANE_BYTES = 16;
  localparam int unsigned LANE_W     = 8 * MAX_BYTES;

  // Reflected Castagnoli polynomial
  localparam logic [CRC_W-1:0] CRC32C_POLY = 32'h82F6_3B78;

  // One input word as held in the input register
  typedef struct packed {
    logic [DATA_W-1:0]  data_high;
    logic [DATA_W-1:0]  data_low;
    logic [COUNT_W-1:0] byte_count;
    logic               first;
  } crc32cw_word_t;

  // Row j selects the lane bits that feed remainder bit j
  typedef logic [CRC_W-1:0][LANE_W-1:0] crc32cw_mat_t;

  // Build the fold matrix: a bit set in lane byte p is carried through the
  // remaining (lanes - p) bytes of shifts starting from a zero remainder.
  function automatic crc32cw_mat_t fold_matrix(int unsigned lanes);
    crc32cw_mat_t     mat;
    logic [CRC_W-1:0] rem;
    mat = '0;
    for (int unsigned p = 0; p < lanes; p++) begin
      for (int unsigned b = 0; b < 8; b++) begin
        rem = {{(CRC_W-1){1'b0}}, 1'b1} << b;
        for (int unsigned s = 0; s < 8 * (lanes - p); s++) begin
          rem = rem[0] ? ((rem >> 1) ^ CRC32C_POLY) : (rem >> 1);
        end
        for (int unsigned j = 0; j < CRC_W; j++) begin
          mat[j][8*p+b] = rem[j];
        end
      end
    end
    return mat;
  endfunction

  localparam crc32cw_mat_t FOLD_MATRIX = fold_matrix(LANE_BYTES);

endpackage

>>> hdl/crc32cw_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32C lane fold
// Advances the remainder over 0 to LANE_BYTES bytes in one XOR network. The
// valid bytes are right-aligned in the lane so leading zeros are neutral, the
// incoming remainder is folded into the first four message bytes, and any
// remainder bytes that lie past the lane end are shifted out directly.
// ----------------------------------------------------------------------------
module crc32cw_fold (
  input  crc32cw_pkg::crc32cw_word_t   word_i,
  input  logic [crc32cw_pkg::CRC_W-1:0] rem_i,
  output logic [crc32cw_pkg::CRC_W-1:0] rem_o
);
  import crc32cw_pkg::*;

  logic [COUNT_W-1:0] n_bytes;
  logic [COUNT_W-1:0] lead_bytes;
  logic [COUNT_W+2:0] lead_bits;
  logic [LANE_W-1:0]  data_aligned;
  logic [LANE_W-1:0]  rem_aligned;
  logic [LANE_W-1:0]  lane;
  logic [CRC_W-1:0]   tail;

  // Saturate the count to the lane size
  assign n_bytes = (word_i.byte_count > COUNT_W'(LANE_BYTES)) ?
                   COUNT_W'(LANE_BYTES) : word_i.byte_count;

  // Zero bytes ahead of the message so it ends at the lane end
  assign lead_bytes = COUNT_W'(LANE_BYTES) - n_bytes;
  assign lead_bits  = {lead_bytes, 3'b000};

  // Align data and remainder; bytes pushed past the lane fall out or are
  // dropped by the matrix
  assign data_aligned = {word_i.data_high, word_i.data_low} << lead_bits;
  assign rem_aligned  = {{(LANE_W-CRC_W){1'b0}}, rem_i} << lead_bits;
  assign lane         = data_aligned ^ rem_aligned;

  // Remainder bytes not yet reached when fewer than four bytes are taken
  always_comb begin
    if (n_bytes < COUNT_W'(4)) begin
      tail = rem_i >> {n_bytes[1:0], 3'b000};
    end else begin
      tail = '0;
    end
  end

  // One XOR tree per remainder bit
  always_comb begin
    for (int unsigned j = 0; j < CRC_W; j++) begin
      rem_o[j] = (^(lane & FOLD_MATRIX[j])) ^ tail[j];
    end
  end

endmodule

>>> hdl/crc32c_wide_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32C wide update
// Running CRC-32C (Castagnoli, reflected) over a stream of up to 16-byte words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word: data_low_i holds
//   bytes 0..7 (byte 0 in bits 7:0), data_high_i bytes 8..15, byte_count_i the
//   number of valid bytes from byte 0 up (saturates at 16) and first_i, which
//   restarts the sum from the programmed start value before the bytes.
//   Output channel (out_valid_o / out_stall_i) returns one word per input word:
//   crc_value_o, the finished CRC of all bytes since the last restart.
//   cfg_wr_en_i writes cfg_wr_data_i into the start value for later restarts;
//   the user must write it only while the block is idle, which is not enforced.
// Timing:
//   An accepted word enters the input register; out_valid_o rises once its result
//   is loaded into the result register. Throughput is one word per cycle while
//   the output does not stall: a word moves from the input register through the
//   single fold network into the result register while the next is accepted.
// Reset and stall:
//   Reset empties both registers, clears the start value to zero and sets the
//   remainder to all ones. While the receiver stalls, the result holds and
//   in_stall_o rises only once the input register is also full.
// ----------------------------------------------------------------------------
module crc32c_wide_update_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_wr_en_i,
  input  logic [crc32cw_pkg::CRC_W-1:0]   cfg_wr_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [crc32cw_pkg::DATA_W-1:0]  data_low_i,
  input  logic [crc32cw_pkg::DATA_W-1:0]  data_high_i,
  input  logic [crc32cw_pkg::COUNT_W-1:0] byte_count_i,
  input  logic                            first_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [crc32cw_pkg::CRC_W-1:0]   crc_value_o
);
  import crc32cw_pkg::*;

  logic            in_valid_q, in_valid_d;
  crc32cw_word_t   word_q;
  logic            out_valid_q, out_valid_d;
  logic [CRC_W-1:0] crc_q;
  logic [CRC_W-1:0] rem_q, rem_d;
  logic [CRC_W-1:0] start_q, start_d;
  logic [CRC_W-1:0] seed;
  logic [CRC_W-1:0] rem_next;
  logic            in_accept;
  logic            advance;

  // Handshake: the held word moves on when the result register frees up
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Restart uses the inverted start value, otherwise the running remainder
  assign seed = word_q.first ? ~start_q : rem_q;

  crc32cw_fold u_fold (
    .word_i (word_q),
    .rem_i  (seed),
    .rem_o  (rem_next)
  );

  // Next state of control and running state
  always_comb begin
    in_valid_d  = in_accept | (in_valid_q & ~advance);
    out_valid_d = advance | (out_valid_q & out_stall_i);
    rem_d       = advance ? rem_next : rem_q;
    start_d     = cfg_wr_en_i ? cfg_wr_data_i : start_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rem_q       <= '1;
      start_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      start_q     <= start_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      word_q.data_low   <= data_low_i;
      word_q.data_high  <= data_high_i;
      word_q.byte_count <= byte_count_i;
      word_q.first      <= first_i;
    end
    if (advance) begin
      crc_q <= ~rem_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = crc_q;

endmodule

>>> hdl/crc32cw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32C wide update port checker
// Watches the top-level ports for pipeline flow and stall behavior.
// ----------------------------------------------------------------------------
module crc32cw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [crc32cw_pkg::CRC_W-1:0] crc_value_o
);

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(crc_value_o)))
    else $error("stalled result changed");

  // Input backs up only when the output side is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled without output backpressure");

  // An accepted word reaches the output once the result register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i) |=> out_valid_o)
    else $error("accepted word did not reach the output");

  // A new result appears only for an accepted word that passed the input register unstalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result word without an accepted input word");

endmodule

bind crc32c_wide_update_top crc32cw_checker u_checker (.*);
